@@ src/fmr_pkg.sv @@
// package for the fraction multiply reduce unit
// holds the sequencer state type, the divider control struct and width constants; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package fmr_pkg;
  localparam int unsigned OPERAND_WIDTH_DEFAULT = 16;
  localparam int unsigned RESULT_WIDTH = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GCD_START,
    ST_GCD_DIV,
    ST_GCD_STEP,
    ST_QN_START,
    ST_QN_WAIT,
    ST_QD_START,
    ST_QD_WAIT,
    ST_MUL,
    ST_DONE
  } fmr_state_t;

  // divider control between sequencer and divider
  typedef struct packed {
    logic start;
  } fmr_div_ctl_t;
endpackage
`default_nettype wire

@@ src/fmr_divider.sv @@
// restoring signed divider, one quotient bit per cycle, truncating like c
// depends on fmr_pkg
`timescale 1ns / 1ps
`default_nettype none
module fmr_divider #(
  parameter int unsigned W = 18
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire fmr_pkg::fmr_div_ctl_t ctl,
  input  wire logic signed [W-1:0]  dividend,
  input  wire logic signed [W-1:0]  divisor,
  output logic signed [W-1:0]       quotient,
  output logic signed [W-1:0]       remainder,
  output logic                      busy
);
  import fmr_pkg::*;

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem_acc;
  logic [W-1:0]  quo;
  logic [W-1:0]  dsr;
  logic [CW-1:0] count;
  logic          neg_q;
  logic          neg_r;
  logic [W:0]    trial;
  logic [W-1:0]  shifted;

  // one restoring step on magnitudes
  always_comb begin
    shifted = {rem_acc[W-2:0], quo[W-1]};
    trial   = {1'b0, shifted} - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (ctl.start) begin
      busy    <= 1'b1;
      count   <= CW'(W);
      rem_acc <= '0;
      quo     <= dividend[W-1] ? -dividend : dividend;
      dsr     <= divisor[W-1] ? -divisor : divisor;
      neg_q   <= dividend[W-1] ^ divisor[W-1];
      neg_r   <= dividend[W-1];
    end else if (busy) begin
      if (trial[W]) begin
        rem_acc <= shifted;
        quo     <= {quo[W-2:0], 1'b0};
      end else begin
        rem_acc <= trial[W-1:0];
        quo     <= {quo[W-2:0], 1'b1};
      end
      count <= count - 1'b1;
      if (count == CW'(1)) busy <= 1'b0;
    end
  end

  assign quotient  = neg_q ? -quo : quo;
  assign remainder = neg_r ? -rem_acc : rem_acc;
endmodule
`default_nettype wire

@@ src/fraction_multiply_reduce_unit.sv @@
// fraction multiply with euclid reduction, one shared sequential divider
// run time is data dependent: the steps of three euclid runs plus up to six
// divides, all on the divider, which is W = 2*OPERAND_WIDTH+2 bits wide;
// one transaction at a time, throughput set by the single bit-serial divider;
// ready again once the result sits in the output register
// synchronous active-high reset clears sequencer and output valid
`timescale 1ns / 1ps
`default_nettype none
module fraction_multiply_reduce_unit #(
  parameter int unsigned OPERAND_WIDTH = fmr_pkg::OPERAND_WIDTH_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic signed [OPERAND_WIDTH-1:0] first_numerator,
  input  wire logic signed [OPERAND_WIDTH-1:0] first_denominator,
  input  wire logic signed [OPERAND_WIDTH-1:0] second_numerator,
  input  wire logic signed [OPERAND_WIDTH-1:0] second_denominator,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [fmr_pkg::RESULT_WIDTH-1:0] product_numerator,
  output logic signed [fmr_pkg::RESULT_WIDTH-1:0] product_denominator,
  output logic                                 zero_denominator
);
  import fmr_pkg::*;

  // products of reduced parts need 2*OW+1 bits; keep margin for negation
  localparam int unsigned W = 2 * OPERAND_WIDTH + 2;

  fmr_state_t state, state_next;
  logic [1:0] phase, phase_next;
  logic signed [W-1:0] n1, d1, n2, d2;
  logic signed [W-1:0] ga, gb;
  logic signed [W-1:0] cur_n, cur_d;
  logic signed [W-1:0] div_a, div_b;
  logic signed [W-1:0] quo, rem;
  logic signed [W-1:0] prod_n, prod_d;
  logic zero_den;
  logic div_busy;
  fmr_div_ctl_t div_ctl;

  fmr_divider #(.W(W)) u_div (
    .clk(clk), .rst(rst), .ctl(div_ctl), .dividend(div_a), .divisor(div_b),
    .quotient(quo), .remainder(rem), .busy(div_busy)
  );

  // operand pair under reduction for the current phase
  always_comb begin
    case (phase)
      2'd0:    begin cur_n = n1; cur_d = d1; end
      2'd1:    begin cur_n = n2; cur_d = d2; end
      default: begin cur_n = n1; cur_d = d1; end
    endcase
  end

  // reduced parts carry at most OPERAND_WIDTH+1 significant bits
  assign prod_n = W'($signed(n1[OPERAND_WIDTH:0])) * W'($signed(n2[OPERAND_WIDTH:0]));
  assign prod_d = W'($signed(d1[OPERAND_WIDTH:0])) * W'($signed(d2[OPERAND_WIDTH:0]));

  assign in_stall = (state != ST_IDLE);

  // sequencer next state
  always_comb begin
    state_next = state;
    phase_next = phase;
    div_ctl    = '0;
    div_a      = ga;
    div_b      = gb;
    unique case (state)
      ST_IDLE: if (in_valid) begin
        state_next = (first_denominator == '0 || second_denominator == '0)
                     ? ST_DONE : ST_GCD_START;
        phase_next = 2'd0;
      end
      ST_GCD_START: state_next = ST_GCD_DIV;
      ST_GCD_DIV: begin
        if (gb == '0) state_next = (ga == '0) ? ST_QN_START : ST_QN_START;
        else begin
          div_ctl.start = 1'b1;
          state_next    = ST_GCD_STEP;
        end
      end
      ST_GCD_STEP: if (!div_busy) state_next = ST_GCD_DIV;
      ST_QN_START: begin
        if (ga == '0) state_next = (phase == 2'd1) ? ST_MUL : ST_QD_WAIT;
        else begin
          div_a = cur_n; div_b = ga; div_ctl.start = 1'b1;
          state_next = ST_QN_WAIT;
        end
      end
      ST_QN_WAIT: if (!div_busy) state_next = ST_QD_START;
      ST_QD_START: begin
        div_a = cur_d; div_b = ga; div_ctl.start = 1'b1;
        state_next = ST_QD_WAIT;
      end
      ST_QD_WAIT: if (!div_busy) begin
        if (phase == 2'd0) begin
          phase_next = 2'd1; state_next = ST_GCD_START;
        end else if (phase == 2'd1) state_next = ST_MUL;
        else state_next = ST_DONE;
      end
      ST_MUL: begin
        phase_next = 2'd2; state_next = ST_GCD_START;
      end
      ST_DONE: if (!out_valid || !out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      if (state == ST_DONE && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: if (in_valid) begin
        n1 <= W'(first_numerator);
        d1 <= W'(first_denominator);
        n2 <= W'(second_numerator);
        d2 <= W'(second_denominator);
        zero_den <= (first_denominator == '0 || second_denominator == '0);
      end
      ST_GCD_START: begin ga <= cur_n; gb <= cur_d; end
      ST_GCD_STEP: if (!div_busy) begin ga <= gb; gb <= rem; end
      ST_QN_WAIT: if (!div_busy) begin
        if (phase == 2'd0) n1 <= quo; else if (phase == 2'd1) n2 <= quo;
        else n1 <= quo;
      end
      ST_QD_WAIT: if (!div_busy) begin
        if (phase == 2'd0) d1 <= quo; else if (phase == 2'd1) d2 <= quo;
        else d1 <= quo;
      end
      ST_MUL: begin
        n1 <= prod_n;
        d1 <= prod_d;
      end
      ST_DONE: if (!out_valid || !out_stall) begin
        zero_denominator    <= zero_den;
        product_numerator   <= zero_den ? '0 : RESULT_WIDTH'(n1);
        product_denominator <= zero_den ? '0 : RESULT_WIDTH'(d1);
      end
      default: ;
    endcase
  end

  // checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall) else $error("accept while busy");
  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_ctl.start |-> !div_busy) else $error("divider restarted while busy");
  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_denominator) |-> (product_numerator == '0 &&
    product_denominator == '0)) else $error("zero denominator result nonzero");
endmodule
`default_nettype wire

@@ tb/sv/fmr_scoreboard.sv @@
// result checker for the fraction multiply reduce unit
// watches both channels, predicts each product and compares; depends on fmr_pkg
`timescale 1ns / 1ps
`default_nettype none
module fmr_scoreboard #(
  parameter int unsigned OPERAND_WIDTH = fmr_pkg::OPERAND_WIDTH_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  input  wire logic                                in_stall,
  input  wire logic signed [OPERAND_WIDTH-1:0]     first_numerator,
  input  wire logic signed [OPERAND_WIDTH-1:0]     first_denominator,
  input  wire logic signed [OPERAND_WIDTH-1:0]     second_numerator,
  input  wire logic signed [OPERAND_WIDTH-1:0]     second_denominator,
  input  wire logic                                out_valid,
  input  wire logic                                out_stall,
  input  wire logic signed [fmr_pkg::RESULT_WIDTH-1:0] product_numerator,
  input  wire logic signed [fmr_pkg::RESULT_WIDTH-1:0] product_denominator,
  input  wire logic                                zero_denominator,
  output int                                       error_count,
  output int                                       pending_count
);
  typedef struct packed {
    logic signed [fmr_pkg::RESULT_WIDTH-1:0] num;
    logic signed [fmr_pkg::RESULT_WIDTH-1:0] den;
    logic                                    zero_den;
  } product_t;

  product_t expected_products[$];

  // euclid with truncating remainder, sign follows the last nonzero remainder
  function automatic longint trunc_gcd(longint a, longint b);
    longint r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  function automatic product_t multiply_reduce(longint n1, longint d1, longint n2, longint d2);
    product_t p;
    longint g, pn, pd;
    p = '0;
    if (d1 == 0 || d2 == 0) begin
      p.zero_den = 1'b1;
      return p;
    end
    g = trunc_gcd(n1, d1);
    n1 = n1 / g;
    d1 = d1 / g;
    g = trunc_gcd(n2, d2);
    n2 = n2 / g;
    d2 = d2 / g;
    pn = n1 * n2;
    pd = d1 * d2;
    g = trunc_gcd(pn, pd);
    pn = pn / g;
    pd = pd / g;
    p.num = pn[31:0];
    p.den = pd[31:0];
    return p;
  endfunction

  assign pending_count = expected_products.size();

  // predict on accepted inputs, compare on accepted outputs
  always @(posedge clk) begin
    product_t want;
    if (rst) begin
      error_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_products.push_back(multiply_reduce(first_numerator, first_denominator,
                                                    second_numerator, second_denominator));
      if (out_valid && !out_stall) begin
        if (expected_products.size() == 0) begin
          if (error_count < 10)
            $display("unexpected result transaction at %0t", $realtime);
          error_count <= error_count + 1;
        end else begin
          want = expected_products.pop_front();
          if (want.num !== product_numerator || want.den !== product_denominator ||
              want.zero_den !== zero_denominator) begin
            if (error_count < 10)
              $display("mismatch: expected %0d/%0d z=%0b, got %0d/%0d z=%0b",
                       want.num, want.den, want.zero_den, product_numerator,
                       product_denominator, zero_denominator);
            error_count <= error_count + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ tb/sv/tb_fraction_multiply_reduce_unit.sv @@
// testbench top for the fraction multiply reduce unit
// drives directed and random fraction pairs; depends on fmr_pkg, the unit and fmr_scoreboard
`timescale 1ns / 1ps
`default_nettype none
module tb_fraction_multiply_reduce_unit;
  localparam int W = fmr_pkg::OPERAND_WIDTH_DEFAULT;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [W-1:0] first_numerator = '0;
  logic signed [W-1:0] first_denominator = '0;
  logic signed [W-1:0] second_numerator = '0;
  logic signed [W-1:0] second_denominator = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] product_numerator;
  logic signed [31:0] product_denominator;
  logic zero_denominator;
  int error_count;
  int pending_count;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always #5 clk = ~clk;

  fraction_multiply_reduce_unit #(.OPERAND_WIDTH(W)) i_dut (.*);

  fmr_scoreboard #(.OPERAND_WIDTH(W)) i_scoreboard (.*);

  // receiver stalls at random
  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  // send one transaction, with an optional random gap first
  task automatic send_fractions(logic [W-1:0] n1, logic [W-1:0] d1,
                                logic [W-1:0] n2, logic [W-1:0] d2);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    first_numerator <= n1;
    first_denominator <= d1;
    second_numerator <= n2;
    second_denominator <= d2;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // mostly small magnitudes so fractions share factors, sometimes full range
  function automatic logic [W-1:0] rand_operand();
    case ($urandom_range(9))
      0, 1, 2, 3: return W'($signed($urandom_range(40)) - 20);
      4, 5: return W'($signed($urandom_range(2000)) - 1000);
      6: return W'($urandom_range(3) == 0 ? 16'h8000 : 16'h7fff);
      default: return W'($urandom);
    endcase
  endfunction

  initial begin
    logic [W-1:0] d1, d2;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, zero numerators and denominators, sign cases
    send_fractions(16'h8000, 16'hffff, 16'h8000, 16'hffff);
    send_fractions(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_fractions(16'h0000, 16'h0005, 16'h0003, 16'hfff9);
    send_fractions(16'h0001, 16'h0000, 16'h0002, 16'h0003);
    send_fractions(16'h0001, 16'h0002, 16'h0002, 16'h0000);
    send_fractions(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_fractions(16'hfffa, 16'h0004, 16'h0006, 16'hfff7);
    send_fractions(16'h0006, 16'hfffc, 16'hfffa, 16'hfff7);
    send_fractions(16'h0000, 16'h8000, 16'h0000, 16'hffff);
    send_fractions(16'hffff, 16'hffff, 16'h0001, 16'h0001);
    send_fractions(16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
    send_fractions(16'h5555, 16'haaaa, 16'h7ffe, 16'h0002);

    // random phases with different idle and stall mixes
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? 46 : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? 46 : 0;
      if (phase == 3) begin
        send_idle_pct = 16;
        recv_stall_pct = 16;
      end
      for (int i = 0; i < 70; i++) begin
        d1 = rand_operand();
        d2 = rand_operand();
        if ($urandom_range(19) == 0) d1 = '0;
        send_fractions(rand_operand(), d1, rand_operand(), d2);
      end
    end
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // timeout
  initial begin
    #300ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
src/fmr_pkg.sv
src/fmr_divider.sv
src/fraction_multiply_reduce_unit.sv
tb/sv/fmr_scoreboard.sv
tb/sv/tb_fraction_multiply_reduce_unit.sv
